FILE: sv/dbrrip_pkg.sv
// ----------------------------------------------------------------------------
// dbrrip_pkg
// Shared types and constants of the dead-block RRIP replacement engine.
// ----------------------------------------------------------------------------
`default_nettype none

package dbrrip_pkg;

  // Default geometry
  localparam int DEF_NUM_SETS = 2048;
  localparam int DEF_NUM_WAYS = 16;

  // Field widths
  localparam int SET_IDX_W = 11;
  localparam int WAY_IDX_W = 4;
  localparam int ADDR_W    = 64;
  localparam int VMASK_W   = 16;
  localparam int CNT_W     = 20;

  // Command codes
  localparam logic CMD_VICTIM = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // Register indexes (paddr[2])
  localparam logic REG_DECAY  = 1'b0;
  localparam logic REG_STREAM = 1'b1;

  // Counter and RRPV limits
  localparam logic [1:0] RRPV_MAX  = 2'd3;
  localparam logic [1:0] CTR_MAX   = 2'd3;
  localparam logic [4:0] LOG2_MAX  = 5'd20;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [4:0] decay_period_log2;
    logic [1:0] stream_insert_rrpv;
  } dbrrip_cfg_t;

  typedef struct packed {
    logic                 command;
    logic [SET_IDX_W-1:0] set_idx;
    logic [WAY_IDX_W-1:0] way;
    logic                 hit;
    logic [ADDR_W-1:0]    addr;
    logic [VMASK_W-1:0]   valid;
    logic                 decay;
  } dbrrip_item_t;

endpackage

`default_nettype wire

FILE: sv/dbrrip_queue.sv
// ----------------------------------------------------------------------------
// dbrrip_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dbrrip_queue (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  input  dbrrip_pkg::dbrrip_item_t push_item,
  output logic                   full,
  input  wire                    pop,
  output dbrrip_pkg::dbrrip_item_t head,
  output logic                   empty
);
  import dbrrip_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  dbrrip_item_t slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] count;

  assign full  = (count == CNT_QW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Advance pointers on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: sv/dbrrip_front.sv
// ----------------------------------------------------------------------------
// dbrrip_front
// Accepts items, folds the set index, drops out-of-range updates and marks
// the updates that trigger a dead-counter decay.
// ----------------------------------------------------------------------------
`default_nettype none

module dbrrip_front #(
  parameter int NUM_SETS = dbrrip_pkg::DEF_NUM_SETS,
  parameter int NUM_WAYS = dbrrip_pkg::DEF_NUM_WAYS
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  dbrrip_pkg::dbrrip_cfg_t              cfg,
  input  wire                                  clearing,
  input  wire                                  push,
  output logic                                 full,
  input  wire                                  command,
  input  wire [dbrrip_pkg::SET_IDX_W-1:0]      set_index,
  input  wire [dbrrip_pkg::WAY_IDX_W-1:0]      way_index,
  input  wire                                  was_hit,
  input  wire [dbrrip_pkg::ADDR_W-1:0]         phys_addr,
  input  wire [dbrrip_pkg::VMASK_W-1:0]        valid_mask,
  input  wire                                  q_full,
  output logic                                 q_push,
  output dbrrip_pkg::dbrrip_item_t             q_item
);
  import dbrrip_pkg::*;

  logic [CNT_W-1:0] update_count;
  logic [CNT_W-1:0] update_count_next;
  logic [CNT_W-1:0] decay_mask;
  logic [4:0]       lg;
  logic             accept;
  logic             keep;
  logic             is_update;

  // Reduce set index modulo NUM_SETS by shifted compare and subtract
  function automatic logic [SET_IDX_W-1:0] set_reduce(input logic [SET_IDX_W-1:0] s);
    longint unsigned r;
    r = longint'(s);
    for (int k = SET_IDX_W - 1; k >= 0; k--) begin
      if (r >= (longint'(NUM_SETS) << k)) begin
        r = r - (longint'(NUM_SETS) << k);
      end
    end
    return SET_IDX_W'(r);
  endfunction

  assign full      = q_full || clearing;
  assign accept    = push && !full;
  assign is_update = (command == CMD_UPDATE);
  assign keep      = !is_update || (32'(way_index) < NUM_WAYS);
  assign q_push    = accept && keep;

  // Decay tick on the incremented update count
  assign lg                = (cfg.decay_period_log2 > LOG2_MAX) ? LOG2_MAX
                                                                : cfg.decay_period_log2;
  assign decay_mask        = (CNT_W'(1) << lg) - CNT_W'(1);
  assign update_count_next = update_count + CNT_W'(1);

  always_comb begin
    q_item.command = command;
    q_item.set_idx = set_reduce(set_index);
    q_item.way     = way_index;
    q_item.hit     = was_hit;
    q_item.addr    = phys_addr;
    q_item.valid   = valid_mask;
    q_item.decay   = is_update && ((update_count_next & decay_mask) == '0);
  end

  // Advance the update count on each kept update
  always_ff @(posedge clk) begin
    if (rst) begin
      update_count <= '0;
    end else if (q_push && is_update) begin
      update_count <= update_count_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/dbrrip_back.sv
// ----------------------------------------------------------------------------
// dbrrip_back
// Holds the per-set metadata and address history memories and carries out
// victim selection, hit and miss updates, decay sweeps and the reset clear.
// ----------------------------------------------------------------------------
`default_nettype none

module dbrrip_back #(
  parameter int NUM_SETS = dbrrip_pkg::DEF_NUM_SETS,
  parameter int NUM_WAYS = dbrrip_pkg::DEF_NUM_WAYS
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  dbrrip_pkg::dbrrip_cfg_t              cfg,
  input  dbrrip_pkg::dbrrip_item_t             q_head,
  input  wire                                  q_empty,
  output logic                                 q_pop,
  output logic                                 clearing,
  output logic                                 empty,
  input  wire                                  pop,
  output logic [dbrrip_pkg::WAY_IDX_W-1:0]     victim_way
);
  import dbrrip_pkg::*;

  localparam int SA    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int PTR_W = $clog2(NUM_SETS + 1);
  localparam int WAY_W = $clog2(NUM_WAYS);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SWEEP = 5'b00100,
    ST_FETCH = 5'b01000,
    ST_EXEC  = 5'b10000
  } state_t;

  typedef logic [NUM_WAYS-1:0][1:0] row_t;

  // Memories
  row_t              rrpv_mem  [NUM_SETS];
  row_t              reuse_mem [NUM_SETS];
  row_t              dead_mem  [NUM_SETS];
  logic [3:0][63:0]  hist_mem  [NUM_SETS];
  logic [1:0]        slot_mem  [NUM_SETS];

  state_t            state, state_next;
  logic [PTR_W-1:0]  ptr, ptr_next;
  dbrrip_item_t      cur;
  logic              out_valid;
  logic [WAY_IDX_W-1:0] out_way;

  // Read port
  logic [SA-1:0]     rd_addr;
  row_t              rrpv_rd, reuse_rd, dead_rd;
  logic [3:0][63:0]  hist_rd;
  logic [1:0]        slot_rd;

  // Write port
  logic              meta_we, hist_we;
  logic [SA-1:0]     wr_addr;
  row_t              rrpv_wd, reuse_wd, dead_wd;
  logic [3:0][63:0]  hist_wd;
  logic [1:0]        slot_wd;

  // Victim selection
  logic [NUM_WAYS-1:0] invalid_v, match_v, top_v;
  logic [NUM_WAYS-1:0] dead3_v, dead2_v, dead1_v, rrpv3_v, rrpv2_v, rrpv1_v;
  logic [1:0]          top_dead, top_rrpv;
  logic [WAY_W-1:0]    pick;
  logic                aging;

  // Update
  logic [WAY_W-1:0]  wi;
  logic [63:0]       d1, d2, d3;
  logic              stream;
  logic [1:0]        ins;
  logic              take;

  function automatic logic [WAY_W-1:0] first_way(input logic [NUM_WAYS-1:0] v);
    logic [WAY_W-1:0] idx;
    idx = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (v[w]) begin
        idx = WAY_W'(w);
      end
    end
    return idx;
  endfunction

  assign clearing   = (state == ST_CLEAR);
  assign empty      = !out_valid;
  assign victim_way = out_way;
  assign take       = (state == ST_IDLE) && !q_empty &&
                      (!out_valid || (q_head.command == CMD_UPDATE));
  assign q_pop      = take;

  // Memory read, registered
  always_ff @(posedge clk) begin
    rrpv_rd  <= rrpv_mem[rd_addr];
    reuse_rd <= reuse_mem[rd_addr];
    dead_rd  <= dead_mem[rd_addr];
    hist_rd  <= hist_mem[rd_addr];
    slot_rd  <= slot_mem[rd_addr];
  end

  // Memory write
  always_ff @(posedge clk) begin
    if (meta_we) begin
      rrpv_mem[wr_addr]  <= rrpv_wd;
      reuse_mem[wr_addr] <= reuse_wd;
      dead_mem[wr_addr]  <= dead_wd;
    end
    if (hist_we) begin
      hist_mem[wr_addr] <= hist_wd;
      slot_mem[wr_addr] <= slot_wd;
    end
  end

  // Classify ways for victim selection
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      invalid_v[w] = (w < VMASK_W) ? ~cur.valid[4'(w)] : 1'b0;
      dead3_v[w]   = (dead_rd[w] == 2'd3);
      dead2_v[w]   = (dead_rd[w] == 2'd2);
      dead1_v[w]   = (dead_rd[w] == 2'd1);
      rrpv3_v[w]   = (rrpv_rd[w] == 2'd3);
      rrpv2_v[w]   = (rrpv_rd[w] == 2'd2);
      rrpv1_v[w]   = (rrpv_rd[w] == 2'd1);
    end
    top_dead = (|dead3_v) ? 2'd3 : (|dead2_v) ? 2'd2 : (|dead1_v) ? 2'd1 : 2'd0;
    top_rrpv = (|rrpv3_v) ? 2'd3 : (|rrpv2_v) ? 2'd2 : (|rrpv1_v) ? 2'd1 : 2'd0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      match_v[w] = (dead_rd[w] == top_dead) && (rrpv_rd[w] == RRPV_MAX);
      top_v[w]   = (rrpv_rd[w] == top_rrpv);
    end
    aging = 1'b0;
    if (|invalid_v) begin
      pick = first_way(invalid_v);
    end else if (|match_v) begin
      pick = first_way(match_v);
    end else begin
      pick  = first_way(top_v);
      aging = 1'b1;
    end
  end

  // Stride detector and insertion RRPV
  assign wi = WAY_W'(cur.way);
  assign d1 = hist_rd[1] - hist_rd[0];
  assign d2 = hist_rd[2] - hist_rd[1];
  assign d3 = cur.addr - hist_rd[2];
  assign stream = (slot_rd == 2'd3) && (d2 == d1) && (d3 == d1);

  always_comb begin
    ins = 2'd2;
    if (reuse_rd[wi] >= 2'd2) begin
      ins = 2'd0;
    end
    if (dead_rd[wi] >= 2'd2) begin
      ins = RRPV_MAX;
    end
    if (stream) begin
      ins = cfg.stream_insert_rrpv;
    end
  end

  // Sequencer and write data
  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    rd_addr    = SA'(cur.set_idx);
    meta_we    = 1'b0;
    hist_we    = 1'b0;
    wr_addr    = SA'(ptr);
    rrpv_wd    = rrpv_rd;
    reuse_wd   = reuse_rd;
    dead_wd    = dead_rd;
    hist_wd    = hist_rd;
    slot_wd    = slot_rd;
    unique case (state)
      ST_CLEAR: begin
        meta_we = 1'b1;
        hist_we = 1'b1;
        for (int w = 0; w < NUM_WAYS; w++) begin
          rrpv_wd[w]  = RRPV_MAX;
          reuse_wd[w] = 2'd1;
          dead_wd[w]  = 2'd0;
        end
        hist_wd = '0;
        slot_wd = '0;
        if (ptr == PTR_W'(NUM_SETS - 1)) begin
          ptr_next   = '0;
          state_next = ST_IDLE;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      ST_IDLE: begin
        rd_addr = SA'(q_head.set_idx);
        if (take) begin
          ptr_next   = '0;
          state_next = q_head.decay ? ST_SWEEP : ST_EXEC;
        end
      end
      ST_SWEEP: begin
        rd_addr = SA'(ptr);
        wr_addr = SA'(ptr - 1'b1);
        meta_we = (ptr != '0);
        for (int w = 0; w < NUM_WAYS; w++) begin
          dead_wd[w] = (dead_rd[w] == 2'd0) ? 2'd0 : dead_rd[w] - 2'd1;
        end
        if (ptr == PTR_W'(NUM_SETS)) begin
          state_next = ST_FETCH;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      ST_FETCH: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        wr_addr    = SA'(cur.set_idx);
        state_next = ST_IDLE;
        if (cur.command == CMD_VICTIM) begin
          meta_we = aging;
          for (int w = 0; w < NUM_WAYS; w++) begin
            rrpv_wd[w] = rrpv_rd[w] + (RRPV_MAX - top_rrpv);
          end
        end else if (cur.hit) begin
          meta_we      = 1'b1;
          rrpv_wd[wi]  = 2'd0;
          reuse_wd[wi] = (reuse_rd[wi] == CTR_MAX) ? CTR_MAX : reuse_rd[wi] + 2'd1;
          dead_wd[wi]  = 2'd0;
        end else begin
          meta_we          = 1'b1;
          hist_we          = 1'b1;
          hist_wd[slot_rd] = cur.addr;
          slot_wd          = slot_rd + 2'd1;
          rrpv_wd[wi]      = ins;
          reuse_wd[wi]     = 2'd1;
          dead_wd[wi]      = (dead_rd[wi] == CTR_MAX) ? CTR_MAX : dead_rd[wi] + 2'd1;
        end
      end
      default: begin
        state_next = ST_CLEAR;
        ptr_next   = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      if ((state == ST_EXEC) && (cur.command == CMD_VICTIM)) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the current item and the result
  always_ff @(posedge clk) begin
    if (take) begin
      cur <= q_head;
    end
    if ((state == ST_EXEC) && (cur.command == CMD_VICTIM)) begin
      out_way <= WAY_IDX_W'(pick);
    end
  end

endmodule

`default_nettype wire

FILE: sv/deadblock_rrip_stream_bypass_replacement.sv
// ----------------------------------------------------------------------------
// deadblock_rrip_stream_bypass_replacement
// Per-set RRIP replacement engine with dead-block counters and a stride
// based stream detector.
//
//   Channel   Handshake            Payload
//   input     push / full          command set_index way_index was_hit
//                                  phys_addr valid_mask
//   result    pop / empty          victim_way
//   config    psel penable pwrite  paddr pwdata prdata (pready tied high)
//
// In the back end an item gets a registered read of its set's metadata row,
// and the row is then computed and written back.
// An update that hits a decay tick first sweeps all sets, one metadata row
// read and written per cycle.
// After reset a clearing pass over all sets holds full high.
// A victim request waits in the queue while an earlier result is untaken.
// ----------------------------------------------------------------------------
`default_nettype none

module deadblock_rrip_stream_bypass_replacement #(
  parameter int NUM_SETS = dbrrip_pkg::DEF_NUM_SETS,
  parameter int NUM_WAYS = dbrrip_pkg::DEF_NUM_WAYS
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               push,
  output logic                              full,
  input  wire                               command,
  input  wire [dbrrip_pkg::SET_IDX_W-1:0]   set_index,
  input  wire [dbrrip_pkg::WAY_IDX_W-1:0]   way_index,
  input  wire                               was_hit,
  input  wire [dbrrip_pkg::ADDR_W-1:0]      phys_addr,
  input  wire [dbrrip_pkg::VMASK_W-1:0]     valid_mask,
  output logic                              empty,
  input  wire                               pop,
  output logic [dbrrip_pkg::WAY_IDX_W-1:0]  victim_way,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire [2:0]                         paddr,
  input  wire [31:0]                        pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import dbrrip_pkg::*;

  dbrrip_cfg_t  cfg;
  dbrrip_item_t q_item;
  dbrrip_item_t q_head;
  logic         q_push, q_full, q_pop, q_empty;
  logic         clearing;

  assign pready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decay_period_log2  <= 5'd12;
      cfg.stream_insert_rrpv <= 2'd3;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_DECAY:  cfg.decay_period_log2  <= pwdata[4:0];
        REG_STREAM: cfg.stream_insert_rrpv <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[2])
      REG_DECAY:  prdata = {27'd0, cfg.decay_period_log2};
      REG_STREAM: prdata = {30'd0, cfg.stream_insert_rrpv};
      default:    prdata = '0;
    endcase
  end

  dbrrip_front #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .clearing   (clearing),
    .push       (push),
    .full       (full),
    .command    (command),
    .set_index  (set_index),
    .way_index  (way_index),
    .was_hit    (was_hit),
    .phys_addr  (phys_addr),
    .valid_mask (valid_mask),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (q_item)
  );

  dbrrip_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  dbrrip_back #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_head     (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .empty      (empty),
    .pop        (pop),
    .victim_way (victim_way)
  );

  // Front never accepts during the clearing pass
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst) clearing |-> full)
    else $error("item accepted during clearing pass");

  // Back pops only a filled queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // Front pushes only into a queue with room
  a_push_room: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("queue pushed while full");

  // A waiting result holds until it is transferred
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(victim_way)))
    else $error("waiting result lost or changed");

endmodule

`default_nettype wire
